/* sv/gasp_pkg.sv */
// Package with shared constants and types for the grid path search block.
`timescale 1ns / 1ps
package gasp_pkg;
    localparam int GRID_SIDE = 8;
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CW = $clog2(CELLS);
    localparam int PW = 3;

    localparam logic [1:0] DIR_UP = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_LEFT = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Commands from controller to datapath.
    typedef struct packed {
        logic init;
        logic scan_clear;
        logic scan_step;
        logic take_best;
        logic nb_step;
        logic close_best;
        logic walk_step;
        logic out_step;
    } gasp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic bad_query;
        logic scan_done;
        logic best_valid;
        logic best_is_goal;
        logic nb_done;
        logic walk_done;
        logic out_done;
    } gasp_stat_t;
endpackage

/* sv/gasp_datapath.sv */
// Datapath: cell state memories, best-cell scan, neighbor update and path walk.
`timescale 1ns / 1ps
module gasp_datapath
    import gasp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  gasp_cmd_t         cmd,
    output gasp_stat_t        stat,
    input  logic [63:0]       blocked_map,
    input  logic [PW-1:0]     start_row,
    input  logic [PW-1:0]     start_col,
    input  logic [PW-1:0]     goal_row,
    input  logic [PW-1:0]     goal_col,
    output logic [PW-1:0]     path_row,
    output logic [PW-1:0]     path_col,
    output logic              path_last
);
    // Per-cell state; open and closed are flip-flop vectors, the rest are arrays.
    logic [CELLS-1:0] open_reg, closed_reg;
    logic [6:0] cost_mem [CELLS];
    logic [1:0] dir_mem [CELLS];
    logic [6:0] ord_mem [CELLS];
    logic [CW-1:0] stack_mem [CELLS];

    logic [6:0] ins_cnt_reg;
    logic [CW-1:0] start_reg, goal_reg, scan_reg, best_reg;
    logic [PW-1:0] grow_reg, gcol_reg;
    logic [7:0] bf_reg;
    logic [6:0] bord_reg;
    logic best_valid_reg, scan_done_reg;
    logic [1:0] nb_reg;
    logic nb_done_reg;
    logic [6:0] best_g_reg;
    logic [CW:0] n_reg, k_reg;
    logic [CW-1:0] cur_reg;
    logic walk_done_reg, out_done_reg;

    // Registered memory read data for the scan, neighbor and walk steps.
    logic [6:0] rd_cost_reg, rd_ord_reg;
    logic [CW-1:0] rd_idx_reg;
    logic rd_vld_reg;
    logic [6:0] nb_cost_reg;
    logic [1:0] dir_rd_reg;
    logic ph_reg;

    // Scan candidate f value, computed from the registered read of the previous scan address.
    logic [PW-1:0] sr, sc;
    logic [PW:0] dr, dc;
    logic [7:0] f;
    logic take_cand;
    assign sr = rd_idx_reg[CW-1:PW];
    assign sc = rd_idx_reg[PW-1:0];
    assign dr = (sr > grow_reg) ? {1'b0, sr - grow_reg} : {1'b0, grow_reg - sr};
    assign dc = (sc > gcol_reg) ? {1'b0, sc - gcol_reg} : {1'b0, gcol_reg - sc};
    assign f = {1'b0, rd_cost_reg} + {4'd0, dr} + {4'd0, dc};
    assign take_cand = rd_vld_reg && (!best_valid_reg || f < bf_reg ||
                       (f == bf_reg && rd_ord_reg > bord_reg));

    // Neighbor selection for the current expansion step.
    logic [PW-1:0] br, bc;
    logic nb_ok;
    logic [CW-1:0] nb_cell;
    logic [1:0] nb_dir;
    assign br = best_reg[CW-1:PW];
    assign bc = best_reg[PW-1:0];
    always_comb
    begin
        nb_ok = 1'b0;
        nb_cell = best_reg;
        nb_dir = DIR_UP;
        case (nb_reg)
            2'd0:
            begin
                nb_ok = (br != '0);
                nb_cell = best_reg - CW'(GRID_SIDE);
                nb_dir = DIR_DOWN;
            end
            2'd1:
            begin
                nb_ok = (br != PW'(GRID_SIDE - 1));
                nb_cell = best_reg + CW'(GRID_SIDE);
                nb_dir = DIR_UP;
            end
            2'd2:
            begin
                nb_ok = (bc != '0);
                nb_cell = best_reg - CW'(1);
                nb_dir = DIR_RIGHT;
            end
            default:
            begin
                nb_ok = (bc != PW'(GRID_SIDE - 1));
                nb_cell = best_reg + CW'(1);
                nb_dir = DIR_LEFT;
            end
        endcase
    end
    logic nb_live;
    logic [6:0] new_g;
    assign nb_live = nb_ok && !blocked_map[nb_cell] && !closed_reg[nb_cell];
    assign new_g = best_g_reg + 7'd1;

    // Parent of the walk cursor, from the direction read in the first phase.
    logic [CW-1:0] parent;
    always_comb
    begin
        case (dir_rd_reg)
            DIR_UP:   parent = cur_reg - CW'(GRID_SIDE);
            DIR_DOWN: parent = cur_reg + CW'(GRID_SIDE);
            DIR_LEFT: parent = cur_reg - CW'(1);
            default:  parent = cur_reg + CW'(1);
        endcase
    end

    // Control flags and counters. Neighbor and walk steps take two phases:
    // a memory read, then the update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
            closed_reg <= '0;
            ins_cnt_reg <= '0;
            scan_reg <= '0;
            best_valid_reg <= 1'b0;
            scan_done_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            nb_reg <= '0;
            nb_done_reg <= 1'b0;
            ph_reg <= 1'b0;
            n_reg <= '0;
            k_reg <= '0;
            cur_reg <= '0;
            walk_done_reg <= 1'b0;
            out_done_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_step && open_reg[scan_reg];
            if (cmd.init)
            begin
                open_reg <= CELLS'(1) << {start_row, start_col};
                closed_reg <= '0;
                ins_cnt_reg <= '0;
                n_reg <= '0;
                walk_done_reg <= 1'b0;
            end
            if (cmd.scan_clear)
            begin
                scan_reg <= '0;
                best_valid_reg <= 1'b0;
                scan_done_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + CW'(1);
                scan_done_reg <= (scan_reg == CW'(CELLS - 1));
            end
            if (take_cand)
            begin
                best_valid_reg <= 1'b1;
            end
            if (cmd.take_best)
            begin
                open_reg[best_reg] <= 1'b0;
                nb_reg <= '0;
                nb_done_reg <= 1'b0;
                ph_reg <= 1'b0;
                cur_reg <= goal_reg;
            end
            if (cmd.nb_step)
            begin
                ph_reg <= !ph_reg;
                if (ph_reg)
                begin
                    if (nb_live && !open_reg[nb_cell])
                    begin
                        open_reg[nb_cell] <= 1'b1;
                        ins_cnt_reg <= ins_cnt_reg + 7'd1;
                    end
                    nb_reg <= nb_reg + 2'd1;
                    nb_done_reg <= (nb_reg == 2'd3);
                end
            end
            if (cmd.close_best)
            begin
                closed_reg[best_reg] <= 1'b1;
            end
            if (cmd.walk_step)
            begin
                ph_reg <= !ph_reg;
                if (ph_reg)
                begin
                    n_reg <= n_reg + (CW+1)'(1);
                    cur_reg <= parent;
                    walk_done_reg <= (cur_reg == start_reg) ||
                                     (n_reg == (CW+1)'(CELLS - 1));
                    k_reg <= n_reg;
                    out_done_reg <= 1'b0;
                end
            end
            if (cmd.out_step)
            begin
                k_reg <= k_reg - (CW+1)'(1);
                out_done_reg <= (k_reg == '0);
            end
        end
    end

    // Payload registers and memories.
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            start_reg <= {start_row, start_col};
            goal_reg <= {goal_row, goal_col};
            grow_reg <= goal_row;
            gcol_reg <= goal_col;
            cost_mem[{start_row, start_col}] <= '0;
            ord_mem[{start_row, start_col}] <= '0;
        end
        if (cmd.scan_step)
        begin
            rd_cost_reg <= cost_mem[scan_reg];
            rd_ord_reg <= ord_mem[scan_reg];
            rd_idx_reg <= scan_reg;
        end
        if (take_cand)
        begin
            best_reg <= rd_idx_reg;
            bf_reg <= f;
            bord_reg <= rd_ord_reg;
            best_g_reg <= rd_cost_reg;
        end
        if (cmd.nb_step && !ph_reg)
        begin
            nb_cost_reg <= cost_mem[nb_cell];
        end
        if (cmd.nb_step && ph_reg && nb_live)
        begin
            if (!open_reg[nb_cell])
            begin
                cost_mem[nb_cell] <= new_g;
                dir_mem[nb_cell] <= nb_dir;
                ord_mem[nb_cell] <= ins_cnt_reg + 7'd1;
            end
            else if (new_g < nb_cost_reg)
            begin
                cost_mem[nb_cell] <= new_g;
                dir_mem[nb_cell] <= nb_dir;
            end
        end
        if (cmd.walk_step && !ph_reg)
        begin
            dir_rd_reg <= dir_mem[cur_reg];
        end
        if (cmd.walk_step && ph_reg)
        begin
            stack_mem[n_reg[CW-1:0]] <= cur_reg;
        end
        if (cmd.out_step)
        begin
            path_row <= stack_mem[k_reg[CW-1:0]][CW-1:PW];
            path_col <= stack_mem[k_reg[CW-1:0]][PW-1:0];
            path_last <= (k_reg == '0);
        end
    end

    assign stat.bad_query = 1'b0;
    assign stat.scan_done = scan_done_reg;
    assign stat.best_valid = best_valid_reg;
    assign stat.best_is_goal = (best_reg == goal_reg);
    assign stat.nb_done = nb_done_reg;
    assign stat.walk_done = walk_done_reg;
    assign stat.out_done = out_done_reg;
endmodule

/* sv/gasp_ctrl.sv */
// Controller state machine sequencing the search, walk-back and result output.
`timescale 1ns / 1ps
module gasp_ctrl
    import gasp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_found,
    output logic       out_none,
    output gasp_cmd_t  cmd,
    input  gasp_stat_t stat
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_PICK = 4'd3;
    localparam logic [3:0] S_NB = 4'd4;
    localparam logic [3:0] S_WALK = 4'd5;
    localparam logic [3:0] S_LOAD = 4'd6;
    localparam logic [3:0] S_SEND = 4'd7;
    localparam logic [3:0] S_NONE = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [6:0] iter_reg, iter_next;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_SEND) || (state_reg == S_NONE);
    assign out_found = (state_reg == S_SEND);
    assign out_none = (state_reg == S_NONE);

    // Next-state and command decode.
    always_comb
    begin
        state_next = state_reg;
        iter_next = iter_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.init = 1'b1;
                    iter_next = '0;
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                cmd.scan_clear = 1'b1;
                state_next = (iter_reg == 7'(CELLS)) ? S_NONE : S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_PICK:
            begin
                if (!stat.best_valid)
                begin
                    state_next = S_NONE;
                end
                else
                begin
                    cmd.take_best = 1'b1;
                    state_next = stat.best_is_goal ? S_WALK : S_NB;
                end
            end
            S_NB:
            begin
                if (stat.nb_done)
                begin
                    cmd.close_best = 1'b1;
                    iter_next = iter_reg + 7'd1;
                    state_next = S_CLR;
                end
                else
                begin
                    cmd.nb_step = 1'b1;
                end
            end
            S_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_LOAD:
            begin
                cmd.out_step = 1'b1;
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_ready)
                begin
                    if (stat.out_done)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.out_step = 1'b1;
                    end
                end
            end
            S_NONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg <= iter_next;
        end
    end
endmodule

/* sv/grid_a_star_path_search_core.sv */
// Top level of the grid A* path search block.
//
// One query enters on the s_axis channel: tdata holds start_row, start_col,
// goal_row and goal_col, three bits each from the lowest bit up. The blocked
// cell bitmap is written through cfg_wr_en and cfg_wr_data; the user must do
// so only while idle, as the block itself does not enforce it. Results leave
// on m_axis, one path cell per item from start to goal; tuser carries the
// found flag and tlast marks the final item of a query. When no path exists
// a single item with found low and a zero cell is sent. The search is one
// query at a time: each expansion scans all 64 cells once through a
// registered memory read, picks the best cell, then visits the four
// neighbors, each with a memory read and then the update. A found path is
// walked back from the goal with a read and an update per cell, then sent.
// The next query is accepted after the last item is taken. A stalled
// receiver holds the current item and the block waits. Reset clears the
// control state and the bitmap; cell state is set per query.
`timescale 1ns / 1ps
module grid_a_star_path_search_core
    import gasp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_row[2:0], start_col[5:3], goal_row[8:6], goal_col[11:9], zero fill
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // path_row[2:0], path_col[5:3], zero fill
    output logic [7:0]  m_axis_tdata,
    // found[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    logic [63:0] blocked_reg;
    gasp_cmd_t cmd;
    gasp_stat_t stat;
    logic found, none;
    logic [PW-1:0] prow, pcol;
    logic plast;

    // Blocked cell bitmap register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocked_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            blocked_reg <= cfg_wr_data;
        end
    end

    gasp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_found (found),
        .out_none  (none),
        .cmd       (cmd),
        .stat      (stat)
    );

    gasp_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .blocked_map (blocked_reg),
        .start_row   (s_axis_tdata[2:0]),
        .start_col   (s_axis_tdata[5:3]),
        .goal_row    (s_axis_tdata[8:6]),
        .goal_col    (s_axis_tdata[11:9]),
        .path_row    (prow),
        .path_col    (pcol),
        .path_last   (plast)
    );

    // Result item: zero cell when no path was found.
    assign m_axis_tdata = found ? {2'b00, pcol, prow} : 8'd0;
    assign m_axis_tuser = found;
    assign m_axis_tlast = none | plast;
endmodule

/* tb/sv/grid_a_star_path_search_core_checker.sv */
// Checker for the grid path search block: predicts paths and compares results.
`timescale 1ns / 1ps
module grid_a_star_path_search_core_checker
    import gasp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          errors,
    output int          pending
);
    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic       found;
        logic       last;
    } path_cell_t;

    path_cell_t  expected_cells[$];
    logic [63:0] wall_map;

    // Open and closed flags, cost, parent direction and entry order per cell.
    logic        open_q[CELLS];
    logic        closed_q[CELLS];
    logic [6:0]  cost_q[CELLS];
    logic [1:0]  dir_q[CELLS];
    logic [6:0]  order_q[CELLS];
    logic [6:0]  order_cnt;

    function automatic int abs_diff(int a, int b);
        return a > b ? a - b : b - a;
    endfunction

    task automatic relax(int r, int c, int from, logic [1:0] dir);
        int idx;
        logic [7:0] g;
        if (r < 0 || r >= GRID_SIDE || c < 0 || c >= GRID_SIDE)
            return;
        idx = r * GRID_SIDE + c;
        if (wall_map[idx] || closed_q[idx])
            return;
        g = {1'b0, cost_q[from]} + 8'd1;
        if (open_q[idx])
        begin
            if (g < {1'b0, cost_q[idx]})
            begin
                cost_q[idx] = g[6:0];
                dir_q[idx] = dir;
            end
            return;
        end
        order_cnt = order_cnt + 7'd1;
        open_q[idx] = 1'b1;
        cost_q[idx] = g[6:0];
        dir_q[idx] = dir;
        order_q[idx] = order_cnt;
    endtask

    // Runs the search for one query and queues the path cells it yields, or a single not-found item.
    task automatic predict_path(logic [15:0] query);
        int sr, sc, gr, gc, start, goal, best, bf, f, cur, n;
        int trail[CELLS];
        path_cell_t pc;
        sr = query[2:0];
        sc = query[5:3];
        gr = query[8:6];
        gc = query[11:9];
        for (int i = 0; i < CELLS; i++)
        begin
            open_q[i] = 1'b0;
            closed_q[i] = 1'b0;
            cost_q[i] = '0;
            dir_q[i] = '0;
            order_q[i] = '0;
        end
        order_cnt = '0;
        start = sr * GRID_SIDE + sc;
        goal = gr * GRID_SIDE + gc;
        open_q[start] = 1'b1;
        for (int it = 0; it < CELLS; it++)
        begin
            best = CELLS;
            bf = 0;
            for (int i = 0; i < CELLS; i++)
            begin
                if (!open_q[i])
                    continue;
                f = cost_q[i] + abs_diff(i / GRID_SIDE, gr) + abs_diff(i % GRID_SIDE, gc);
                if (best == CELLS || f < bf || (f == bf && order_q[i] > order_q[best]))
                begin
                    best = i;
                    bf = f;
                end
            end
            if (best == CELLS)
                break;
            open_q[best] = 1'b0;
            if (best == goal)
            begin
                // Walk back from the goal, then emit from the start forward.
                n = 0;
                cur = goal;
                while (n < CELLS)
                begin
                    trail[n] = cur;
                    n++;
                    if (cur == start)
                        break;
                    case (dir_q[cur])
                        DIR_UP:    cur = cur - GRID_SIDE;
                        DIR_DOWN:  cur = cur + GRID_SIDE;
                        DIR_LEFT:  cur = cur - 1;
                        default:   cur = cur + 1;
                    endcase
                    cur = ((cur % CELLS) + CELLS) % CELLS;
                end
                for (int k = 0; k < n; k++)
                begin
                    pc.row = 3'(trail[n - 1 - k] / GRID_SIDE);
                    pc.col = 3'(trail[n - 1 - k] % GRID_SIDE);
                    pc.found = 1'b1;
                    pc.last = (k + 1 == n);
                    expected_cells.push_back(pc);
                end
                return;
            end
            relax(best / GRID_SIDE - 1, best % GRID_SIDE, best, DIR_DOWN);
            relax(best / GRID_SIDE + 1, best % GRID_SIDE, best, DIR_UP);
            relax(best / GRID_SIDE, best % GRID_SIDE - 1, best, DIR_RIGHT);
            relax(best / GRID_SIDE, best % GRID_SIDE + 1, best, DIR_LEFT);
            closed_q[best] = 1'b1;
        end
        pc = '{row: 3'd0, col: 3'd0, found: 1'b0, last: 1'b1};
        expected_cells.push_back(pc);
    endtask

    assign pending = expected_cells.size();

    // Track the map, predict each accepted query and check each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_map <= '0;
            errors <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                wall_map <= cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_path(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_cells.size() == 0)
                begin
                    $display("%0t: unexpected result row %0d col %0d found %0b last %0b",
                             $time, m_axis_tdata[2:0], m_axis_tdata[5:3],
                             m_axis_tuser, m_axis_tlast);
                    errors <= errors + 1;
                end
                else
                begin
                    path_cell_t want;
                    want = expected_cells.pop_front();
                    if (m_axis_tuser !== want.found || m_axis_tlast !== want.last ||
                        m_axis_tdata[7:6] !== 2'b00 || (want.found &&
                        (m_axis_tdata[2:0] !== want.row || m_axis_tdata[5:3] !== want.col)))
                    begin
                        $display("%0t: mismatch expected row %0d col %0d found %0b last %0b, got row %0d col %0d found %0b last %0b",
                                 $time, want.row, want.col, want.found, want.last,
                                 m_axis_tdata[2:0], m_axis_tdata[5:3],
                                 m_axis_tuser, m_axis_tlast);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/sv/grid_a_star_path_search_core_tb.sv */
// Testbench top for the grid path search block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module grid_a_star_path_search_core_tb;
    import gasp_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [63:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    int          errors;
    int          pending;
    int          cycle_count = 0;
    int          hold_off = 0;

    always #4 clk = ~clk;

    grid_a_star_path_search_core u_top (.*);

    grid_a_star_path_search_core_checker u_checker (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 2);
    endfunction

    // Send one query, then idle for a random gap unless the gap drawn is zero.
    task automatic send_query(int sr, int sc, int gr, int gc);
        int gap;
        s_axis_tdata <= {4'd0, gc[2:0], gr[2:0], sc[2:0], sr[2:0]};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        gap = gap_len();
        if (gap == 0)
            return;
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // Lower valid, wait for all paths, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_map(logic [63:0] map);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= map;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_queries(int count);
        repeat (count)
            send_query($urandom_range(0, 7), $urandom_range(0, 7),
                       $urandom_range(0, 7), $urandom_range(0, 7));
    endtask

    // Receiver: random stalls, with one long hold-off counted here, and always ready late in the run.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else if (cycle_count > 4000 && cycle_count < 4010)
        begin
            hold_off <= 20000;
            m_axis_tready <= 1'b0;
        end
        else if (cycle_count > 150000)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 9) < 7);
    end

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty map: corners, same cell, long paths.
        send_query(0, 0, 7, 7);
        send_query(7, 7, 0, 0);
        send_query(3, 4, 3, 4);
        send_query(0, 7, 7, 0);
        send_query(7, 0, 0, 7);
        send_query(5, 2, 5, 3);
        drain();

        // Wall across row 3 with one hole; blocked start and goal cases.
        write_map(64'h0000_0000_7F00_0000 | 64'h0000_0000_0000_0001);
        send_query(0, 0, 7, 7);
        send_query(1, 1, 0, 0);
        send_query(0, 0, 0, 0);
        send_query(0, 0, 6, 6);
        send_query(3, 2, 5, 5);
        drain();

        // Full wall across row 4 cuts the grid: no path across it.
        write_map(64'h0000_00FF_0000_0000);
        send_query(0, 0, 7, 7);
        send_query(4, 4, 4, 4);
        send_query(5, 3, 1, 6);
        drain();

        // Everything blocked.
        write_map('1);
        send_query(2, 2, 2, 3);
        send_query(6, 6, 6, 6);
        drain();

        // Random sparse maps with random queries, most results found.
        repeat (6)
        begin
            write_map({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
            random_queries(10);
            drain();
        end
        // A dense random map and an open one.
        write_map({$urandom, $urandom} | {$urandom, $urandom});
        random_queries(10);
        drain();
        write_map('0);
        random_queries(10);
        drain();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
